/* rtl/rci_pkg.sv */
// ----------------------------------------------------------------------------
// rci_pkg
// Shared widths, constants, command codes and the control and status bundles
// of the range curve interpolator.
// ----------------------------------------------------------------------------
package rci_pkg;

  // table geometry
  localparam int NUM_SAMPLES = 60;
  localparam int IDX_W       = $clog2(NUM_SAMPLES);

  // field widths
  localparam int CMD_W       = 2;
  localparam int IDX_IN_W    = 6;
  localparam int SAMPLE_W    = 16;
  localparam int DIST_W      = 22;
  localparam int RANGE_W     = 12;

  // fixed point constants: one step of 50 units in Q13.8
  localparam int STEP_LSB    = 12800;
  localparam int HALF_STEP   = STEP_LSB / 2;
  localparam int RANGE_STEP  = 50;
  localparam int RANGE_MAX   = 4095;

  // divide by the step as a shift by 9 and a divide by 25, the latter
  // through ceil(2^26 / 25), exact for operands below 2^26 / 11
  localparam int STEP_SHIFT  = 9;
  localparam int RECIP_25    = 2684355;
  localparam int RECIP_SHIFT = 26;
  localparam int RECIP_W     = 22;

  // internal widths
  localparam int D_W         = DIST_W + 1;
  localparam int BASE_W      = $clog2(NUM_SAMPLES * STEP_LSB + 1);
  localparam int OFS_W       = ((D_W > BASE_W) ? D_W : BASE_W) + 1;
  localparam int FRAC_W      = $clog2(STEP_LSB);
  localparam int DIFF_W      = SAMPLE_W + 1;
  localparam int PROD_W      = DIFF_W + FRAC_W + 1;
  localparam int QUO_W       = SAMPLE_W;
  localparam int MAG_W       = QUO_W + FRAC_W;
  localparam int MQ_W        = MAG_W - STEP_SHIFT;
  localparam int RP_W        = MQ_W + RECIP_W;
  localparam int LP_W        = $clog2(NUM_SAMPLES + 1);
  localparam int RNG_W       = LP_W + $clog2(RANGE_STEP + 1);

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_e;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic exec;
    logic scan_rd;
    logic mul;
    logic div_load;
    logic div_step;
    logic load_out;
  } rci_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
    logic need_interp;
  } rci_sts_t;

endpackage

/* rtl/range_curve_interpolator_top.sv */
// ----------------------------------------------------------------------------
// range_curve_interpolator_top
// Piecewise linear curve lookup over a table of samples 50 units apart.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one beat per command:
//   clear the table, write one sample, or query the curve at a distance.
//   Output channel (out_valid_o / out_ready_i) returns exactly one beat per
//   input beat: curve value (zero unless a query), table peak and effective
//   range, both taken after the command has been applied.
//   Every beat walks all 60 table entries through the single read port
//   of the sample RAM, and a new beat is accepted only once the result
//   of the previous one has been loaded into the output register. A
//   query that falls between two samples adds the multiply, the shift
//   and the reciprocal divide by the sample spacing.
//   Reset clears the table at once through per-entry valid bits; the block
//   is ready as soon as reset is released.
//   When the receiver stalls, the result waits in the output register; the
//   next beat is still accepted and processed and then waits for the output
//   register to free up before it is delivered.
// ----------------------------------------------------------------------------
module range_curve_interpolator_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [rci_pkg::CMD_W-1:0]           cmd_i,
  input  logic [rci_pkg::IDX_IN_W-1:0]        sample_index_i,
  input  logic signed [rci_pkg::SAMPLE_W-1:0] sample_value_i,
  input  logic signed [rci_pkg::DIST_W-1:0]   query_distance_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [rci_pkg::SAMPLE_W-1:0] curve_value_o,
  output logic signed [rci_pkg::SAMPLE_W-1:0] peak_value_o,
  output logic [rci_pkg::RANGE_W-1:0]         effective_range_o
);
  import rci_pkg::*;

  rci_ctl_t ctl;
  rci_sts_t sts;

  // sequencer
  rci_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ctl_o       (ctl),
    .sts_i       (sts)
  );

  // table and arithmetic
  rci_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .ctl_i             (ctl),
    .sts_o             (sts),
    .cmd_i             (cmd_i),
    .sample_index_i    (sample_index_i),
    .sample_value_i    (sample_value_i),
    .query_distance_i  (query_distance_i),
    .curve_value_o     (curve_value_o),
    .peak_value_o      (peak_value_o),
    .effective_range_o (effective_range_o)
  );

  // a pending result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.load_out |-> (!out_valid_o || out_ready_i))
    else $error("output register overwritten");

  // one beat in flight: no acceptance in the cycle after an acceptance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second beat accepted while busy");

  // multiplier only runs when the query lies between two samples
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.mul |-> sts.need_interp)
    else $error("interpolation started without a bracketing interval");

  // a result is loaded only after the scan has drained
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.load_out |-> !ctl.scan_rd && !$past(ctl.scan_rd))
    else $error("result loaded during table scan");

endmodule

/* rtl/rci_ram.sv */
// ----------------------------------------------------------------------------
// rci_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module rci_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/rci_ctrl.sv */
// ----------------------------------------------------------------------------
// rci_ctrl
// Sequencer of the range curve interpolator: accepts a beat, applies the
// command, walks the table, runs the interpolation and hands the result to
// the output register.
// ----------------------------------------------------------------------------
module rci_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output rci_pkg::rci_ctl_t ctl_o,
  input  rci_pkg::rci_sts_t sts_i
);
  import rci_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_TAIL,
    S_MUL,
    S_DLOAD,
    S_DIV,
    S_FIN
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;

  // command decode per state
  always_comb begin
    ctl_o          = '0;
    state_d        = state_q;
    unique case (state_q)
      S_IDLE: begin
        ctl_o.accept = in_valid_i;
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        ctl_o.exec = 1'b1;
        state_d    = S_SCAN;
      end
      S_SCAN: begin
        ctl_o.scan_rd = 1'b1;
        if (sts_i.scan_last) state_d = S_TAIL;
      end
      S_TAIL: begin
        state_d = sts_i.need_interp ? S_MUL : S_FIN;
      end
      S_MUL: begin
        ctl_o.mul = 1'b1;
        state_d   = S_DLOAD;
      end
      S_DLOAD: begin
        ctl_o.div_load = 1'b1;
        state_d        = S_DIV;
      end
      S_DIV: begin
        ctl_o.div_step = 1'b1;
        state_d        = S_FIN;
      end
      S_FIN: begin
        ctl_o.load_out = !out_valid_q || out_ready_i;
        if (ctl_o.load_out) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ctl_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

/* rtl/rci_datapath.sv */
// ----------------------------------------------------------------------------
// rci_datapath
// Sample table with valid bits, scan logic for peak, range and the two
// bracketing samples, multiplier, reciprocal divider by the step size and
// the output register.
// ----------------------------------------------------------------------------
module rci_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rci_pkg::rci_ctl_t                   ctl_i,
  output rci_pkg::rci_sts_t                   sts_o,
  input  logic [rci_pkg::CMD_W-1:0]           cmd_i,
  input  logic [rci_pkg::IDX_IN_W-1:0]        sample_index_i,
  input  logic signed [rci_pkg::SAMPLE_W-1:0] sample_value_i,
  input  logic signed [rci_pkg::DIST_W-1:0]   query_distance_i,
  output logic signed [rci_pkg::SAMPLE_W-1:0] curve_value_o,
  output logic signed [rci_pkg::SAMPLE_W-1:0] peak_value_o,
  output logic [rci_pkg::RANGE_W-1:0]         effective_range_o
);
  import rci_pkg::*;

  // latched beat
  cmd_e                       op_q;
  logic [IDX_IN_W-1:0]        idx_q;
  logic signed [SAMPLE_W-1:0] val_q;
  logic signed [D_W-1:0]      d_q;

  // table
  logic [NUM_SAMPLES-1:0]     valid_q;
  logic                       idx_ok;
  logic                       ram_we;
  logic [IDX_W-1:0]           ram_waddr;
  logic [SAMPLE_W-1:0]        ram_rdata;

  // scan
  logic [IDX_W-1:0]           scan_addr_q;
  logic                       rd_valid_q;
  logic [IDX_W-1:0]           rd_idx_q;
  logic                       rd_ok_q;
  logic signed [SAMPLE_W-1:0] entry;
  logic [BASE_W-1:0]          base_q;
  logic signed [OFS_W-1:0]    ofs;
  logic                       hit;
  logic                       found_q;
  logic                       take_hi_q;
  logic signed [SAMPLE_W-1:0] s0_q, s_lo_q, s_hi_q, s_last_q, peak_q;
  logic [FRAC_W-1:0]          r_q;
  logic [LP_W-1:0]            lp1_q;
  logic                       d_pos;

  // interpolation
  logic signed [DIFF_W-1:0]   diff;
  logic signed [FRAC_W:0]     r_ext;
  logic signed [PROD_W-1:0]   prod_full;
  logic signed [PROD_W-1:0]   prod_q;
  logic [PROD_W-1:0]          mag;
  logic                       neg_q;
  logic [MQ_W-1:0]            mq_q;
  logic [RP_W-1:0]            recip_prod;
  logic [QUO_W-1:0]           qmag_q;
  logic signed [QUO_W:0]      quo;
  logic signed [SAMPLE_W:0]   interp_sum;

  // result
  logic signed [SAMPLE_W-1:0] curve_sel;
  logic [RNG_W-1:0]           rng;
  logic [RANGE_W-1:0]         rng_sat;
  logic signed [SAMPLE_W-1:0] curve_q, peak_out_q;
  logic [RANGE_W-1:0]         range_q;

  // beat capture, distance measured from the first sample
  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      op_q  <= cmd_e'(cmd_i);
      idx_q <= sample_index_i;
      val_q <= sample_value_i;
      d_q   <= D_W'(query_distance_i) - D_W'(STEP_LSB);
    end
  end

  // table write and valid bits
  assign idx_ok    = 32'(idx_q) < 32'(NUM_SAMPLES);
  assign ram_we    = ctl_i.exec && (op_q == CMD_WRITE) && idx_ok;
  assign ram_waddr = IDX_W'(idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ctl_i.exec && (op_q == CMD_CLEAR)) begin
      valid_q <= '0;
    end else if (ram_we) begin
      valid_q[ram_waddr] <= 1'b1;
    end
  end

  rci_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (NUM_SAMPLES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (val_q),
    .raddr_i (scan_addr_q),
    .rdata_o (ram_rdata)
  );

  // scan address and read pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_addr_q <= '0;
      rd_valid_q  <= 1'b0;
    end else begin
      rd_valid_q <= ctl_i.scan_rd;
      if (ctl_i.exec) begin
        scan_addr_q <= '0;
      end else if (ctl_i.scan_rd) begin
        scan_addr_q <= scan_addr_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= scan_addr_q;
    rd_ok_q  <= valid_q[scan_addr_q];
  end

  assign sts_o.scan_last = (scan_addr_q == IDX_W'(NUM_SAMPLES - 1));

  // unwritten entries read as zero
  assign entry = rd_ok_q ? $signed(ram_rdata) : '0;

  // offset of the query inside the current interval
  assign ofs = OFS_W'(d_q) - OFS_W'(base_q);
  assign hit = !ofs[OFS_W-1] && (ofs < OFS_W'(STEP_LSB))
               && (32'(rd_idx_q) < 32'(NUM_SAMPLES - 1));

  // per entry: peak, last positive entry, bracketing samples
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q   <= 1'b0;
      take_hi_q <= 1'b0;
      lp1_q     <= '0;
      base_q    <= '0;
    end else if (ctl_i.exec) begin
      found_q   <= 1'b0;
      take_hi_q <= 1'b0;
      lp1_q     <= '0;
      base_q    <= '0;
    end else if (rd_valid_q) begin
      base_q    <= base_q + BASE_W'(STEP_LSB);
      take_hi_q <= hit;
      if (hit) found_q <= 1'b1;
      if (entry > 0) lp1_q <= LP_W'(rd_idx_q) + LP_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_valid_q) begin
      if (rd_idx_q == '0) begin
        s0_q   <= entry;
        peak_q <= entry;
      end else if (peak_q < entry) begin
        peak_q <= entry;
      end
      if (take_hi_q) s_hi_q <= entry;
      if (hit) begin
        s_lo_q <= entry;
        r_q    <= FRAC_W'(ofs);
      end
      if (rd_idx_q == IDX_W'(NUM_SAMPLES - 1)) s_last_q <= entry;
    end
  end

  assign d_pos             = !d_q[D_W-1] && (d_q != '0);
  assign sts_o.need_interp = (op_q == CMD_QUERY) && d_pos && found_q;

  // slope times offset, rounded half up before the floor divide
  assign diff      = DIFF_W'(s_hi_q) - DIFF_W'(s_lo_q);
  assign r_ext     = {1'b0, r_q};
  assign prod_full = diff * r_ext;

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul) begin
      prod_q <= prod_full + PROD_W'(HALF_STEP);
    end
  end

  // floor divide by the step: magnitude, biased up for negative numerators,
  // then the power of two part of the step shifted out
  assign mag = prod_q[PROD_W-1] ? PROD_W'(-prod_q + PROD_W'(STEP_LSB - 1))
                                : PROD_W'(prod_q);

  always_ff @(posedge clk_i) begin
    if (ctl_i.div_load) begin
      neg_q <= prod_q[PROD_W-1];
      mq_q  <= mag[MAG_W-1:STEP_SHIFT];
    end
  end

  // remaining divide by 25 through the scaled reciprocal
  assign recip_prod = RP_W'(mq_q) * RP_W'(RECIP_25);

  always_ff @(posedge clk_i) begin
    if (ctl_i.div_step) begin
      qmag_q <= recip_prod[RECIP_SHIFT +: QUO_W];
    end
  end

  assign quo        = neg_q ? -$signed({1'b0, qmag_q}) : $signed({1'b0, qmag_q});
  assign interp_sum = (SAMPLE_W + 1)'(s_lo_q) + quo;

  // curve value selection
  always_comb begin
    case (op_q)
      CMD_QUERY: begin
        if (!d_pos) begin
          curve_sel = s0_q;
        end else if (found_q) begin
          curve_sel = interp_sum[SAMPLE_W-1:0];
        end else begin
          curve_sel = s_last_q;
        end
      end
      default: curve_sel = '0;
    endcase
  end

  // effective range with saturation
  assign rng     = RNG_W'(lp1_q) * RNG_W'(RANGE_STEP);
  assign rng_sat = (32'(rng) > 32'(RANGE_MAX)) ? RANGE_W'(RANGE_MAX) : RANGE_W'(rng);

  // output register
  always_ff @(posedge clk_i) begin
    if (ctl_i.load_out) begin
      curve_q    <= curve_sel;
      peak_out_q <= peak_q;
      range_q    <= rng_sat;
    end
  end

  assign curve_value_o     = curve_q;
  assign peak_value_o      = peak_out_q;
  assign effective_range_o = range_q;

endmodule
